// ===== rtl/core/mtl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtl_pkg
// Shared types and constants of the markup token lexer.
// ----------------------------------------------------------------------------
package mtl_pkg;

	localparam int MaxResults = 4;
	localparam int QueueDepth = 2;
	localparam int CountW     = $clog2(MaxResults + 1);

	localparam logic [7:0] ChLt    = 8'h3C;
	localparam logic [7:0] ChSlash = 8'h2F;
	localparam logic [7:0] ChGt    = 8'h3E;
	localparam logic [7:0] ChEq    = 8'h3D;
	localparam logic [7:0] ChSp    = 8'h20;
	localparam logic [7:0] ChSq    = 8'h27;
	localparam logic [7:0] ChDq    = 8'h22;

	localparam logic [2:0] KindOpenSlash = 3'd0;
	localparam logic [2:0] KindOpen      = 3'd1;
	localparam logic [2:0] KindClose     = 3'd2;
	localparam logic [2:0] KindEquals    = 3'd3;
	localparam logic [2:0] KindSq        = 3'd4;
	localparam logic [2:0] KindDq        = 3'd5;
	localparam logic [2:0] KindName      = 3'd6;
	localparam logic [2:0] KindText      = 3'd7;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_NAME,
		MODE_TEXT,
		MODE_SQ0,
		MODE_SQ1,
		MODE_DQ0,
		MODE_DQ1
	} mode_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       line_end;
	} in_item_t;

	typedef struct packed {
		logic [2:0] token_kind;
		logic [7:0] char_code;
		logic       has_char;
		logic       token_start;
		logic       token_end;
		logic       last;
	} out_item_t;

	// all results caused by one input byte
	typedef struct packed {
		logic [CountW-1:0]                count;
		out_item_t [MaxResults-1:0]       res;
	} bundle_t;

endpackage

// ===== rtl/core/mtl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtl_front
// Lexer state machine: classifies one byte per transfer into a result bundle.
// ----------------------------------------------------------------------------
module mtl_front import mtl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t item,
	output logic     push,
	output bundle_t  bundle
);

	mode_t       mode_q, mode_d;
	logic        tag_q, tag_d;
	logic        pend_q, pend_d;
	logic [CountW-1:0] n;
	logic        do_idle;
	logic        consumed;
	logic [7:0]  b;
	out_item_t [MaxResults-1:0] res;

	function automatic out_item_t mk(logic [2:0] k, logic [7:0] c, logic h,
			logic st, logic en);
		out_item_t r;
		r.token_kind  = k;
		r.char_code   = c;
		r.has_char    = h;
		r.token_start = st;
		r.token_end   = en;
		r.last        = 1'b0;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			tag_q  <= 1'b0;
			pend_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			tag_q  <= tag_d;
			pend_q <= pend_d;
		end
	end

	always_comb begin
		b        = item.byte_value;
		mode_d   = mode_q;
		tag_d    = tag_q;
		pend_d   = pend_q;
		n        = '0;
		res      = '0;
		do_idle  = 1'b0;
		consumed = 1'b0;

		// held '<' resolved by this byte
		if (pend_q) begin
			pend_d = 1'b0;
			if (b == ChSlash) begin
				res[n[1:0]] = mk(KindOpenSlash, 8'h00, 1'b0, 1'b1, 1'b1);
				consumed = 1'b1;
			end else begin
				res[n[1:0]] = mk(KindOpen, 8'h00, 1'b0, 1'b1, 1'b1);
			end
			n = n + 1'b1;
		end

		if (!consumed) begin
			unique case (mode_q) inside
				MODE_NAME: begin
					if (b == ChSp || b == ChGt || b == ChEq) begin
						res[n[1:0]] = mk(KindName, 8'h00, 1'b0, 1'b0, 1'b1);
						n = n + 1'b1;
						do_idle = 1'b1;
					end else begin
						res[n[1:0]] = mk(KindName, b, 1'b1, 1'b0, 1'b0);
						n = n + 1'b1;
					end
				end
				MODE_TEXT: begin
					if (b == ChLt) begin
						res[n[1:0]] = mk(KindText, 8'h00, 1'b0, 1'b0, 1'b1);
						n = n + 1'b1;
						do_idle = 1'b1;
					end else begin
						res[n[1:0]] = mk(KindText, b, 1'b1, 1'b0, 1'b0);
						n = n + 1'b1;
					end
				end
				MODE_SQ0, MODE_SQ1: begin
					if (b == ChSq) begin
						res[n[1:0]] = mk(KindSq, 8'h00, 1'b0, mode_q == MODE_SQ0, 1'b1);
						mode_d = MODE_IDLE;
					end else begin
						res[n[1:0]] = mk(KindSq, b, 1'b1, mode_q == MODE_SQ0, 1'b0);
						mode_d = MODE_SQ1;
					end
					n = n + 1'b1;
				end
				MODE_DQ0, MODE_DQ1: begin
					if (b == ChDq) begin
						res[n[1:0]] = mk(KindDq, 8'h00, 1'b0, mode_q == MODE_DQ0, 1'b1);
						mode_d = MODE_IDLE;
					end else begin
						res[n[1:0]] = mk(KindDq, b, 1'b1, mode_q == MODE_DQ0, 1'b0);
						mode_d = MODE_DQ1;
					end
					n = n + 1'b1;
				end
				default: do_idle = 1'b1;
			endcase
		end

		// between tokens
		if (do_idle) begin
			mode_d = MODE_IDLE;
			if (b == ChLt) begin
				pend_d = 1'b1;
				tag_d  = 1'b1;
			end else if (b == ChGt) begin
				tag_d = 1'b0;
				res[n[1:0]] = mk(KindClose, 8'h00, 1'b0, 1'b1, 1'b1);
				n = n + 1'b1;
			end else if (b == ChEq) begin
				res[n[1:0]] = mk(KindEquals, 8'h00, 1'b0, 1'b1, 1'b1);
				n = n + 1'b1;
			end else if (b == ChSq && tag_q) begin
				mode_d = MODE_SQ0;
			end else if (b == ChDq && tag_q) begin
				mode_d = MODE_DQ0;
			end else if (b == ChSp) begin
				mode_d = MODE_IDLE;
			end else if (tag_q) begin
				res[n[1:0]] = mk(KindName, b, 1'b1, 1'b1, 1'b0);
				n = n + 1'b1;
				mode_d = MODE_NAME;
			end else begin
				res[n[1:0]] = mk(KindText, b, 1'b1, 1'b1, 1'b0);
				n = n + 1'b1;
				mode_d = MODE_TEXT;
			end
		end

		// end of line closes whatever is open
		if (item.line_end) begin
			unique case (mode_d) inside
				MODE_NAME: begin
					res[n[1:0]] = mk(KindName, 8'h00, 1'b0, 1'b0, 1'b1);
					n = n + 1'b1;
				end
				MODE_TEXT: begin
					res[n[1:0]] = mk(KindText, 8'h00, 1'b0, 1'b0, 1'b1);
					n = n + 1'b1;
				end
				MODE_SQ0, MODE_SQ1: begin
					res[n[1:0]] = mk(KindSq, 8'h00, 1'b0, mode_d == MODE_SQ0, 1'b1);
					n = n + 1'b1;
				end
				MODE_DQ0, MODE_DQ1: begin
					res[n[1:0]] = mk(KindDq, 8'h00, 1'b0, mode_d == MODE_DQ0, 1'b1);
					n = n + 1'b1;
				end
				default: ;
			endcase
			if (pend_d) begin
				res[n[1:0]] = mk(KindOpen, 8'h00, 1'b0, 1'b1, 1'b1);
				n = n + 1'b1;
			end
			mode_d = MODE_IDLE;
			tag_d  = 1'b0;
			pend_d = 1'b0;
		end

		if (n != '0) begin
			res[2'(n - 1'b1)].last = 1'b1;
		end
	end

	assign push         = accept && (n != '0);
	assign bundle.count = n;
	assign bundle.res   = res;

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (bundle.count <= CountW'(3)))
		else $error("bundle holds more results than a byte can cause");

endmodule

// ===== rtl/core/mtl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtl_queue
// Small FIFO of result bundles between the lexer and the output serialiser.
// ----------------------------------------------------------------------------
module mtl_queue import mtl_pkg::*; #(
	parameter int QDepth = QueueDepth
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t wr_data,
	output logic    full,
	input  logic    pop,
	output logic    head_valid,
	output bundle_t head
);

	localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int CntW = $clog2(QDepth + 1);

	bundle_t         mem_q [QDepth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
		return (p == PtrW'(QDepth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

	assign full       = (cnt_q == CntW'(QDepth));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(QDepth))
		else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

endmodule

// ===== rtl/core/mtl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtl_back
// Output serialiser: sends the results of each bundle one per transfer.
// ----------------------------------------------------------------------------
module mtl_back import mtl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  bundle_t   head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int IdxW = $clog2(MaxResults);

	logic [IdxW-1:0] idx_q;
	logic            valid_q;
	out_item_t       data_q;
	logic            load;
	logic            final_slot;

	assign load       = head_valid && (!valid_q || !out_stall);
	assign final_slot = (CountW'(idx_q) + 1'b1) == head.count;
	assign pop        = load && final_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= final_slot ? '0 : idx_q + 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) data_q <= head.res[idx_q];
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (CountW'(idx_q) < head.count))
		else $error("slot index past bundle count");

	a_bundle_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (head.count != '0))
		else $error("empty bundle in queue");

	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> data_q.last)
		else $error("bundle retired without its last result");

endmodule

// ===== rtl/core/markup_token_lexer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markup_token_lexer_unit
// Streaming markup lexer: one line in a byte at a time, classified tokens out.
// ----------------------------------------------------------------------------
//  channel   valid       stall       payload     moves
//  input     byte_valid  byte_stall  byte_item   one line byte per transfer
//  output    tok_valid   tok_stall   tok_item    one token result per transfer
//
//  a byte is taken every cycle while the bundle queue has room
//  each byte yields 0 to 3 results; the serialiser sends one result a cycle
//  while the output is not stalled
//  the first result of a byte is registered in the bundle queue, then in the
//  serialiser's output register, before it is transferred
//  asynchronous reset returns the lexer to idle outside any tag
//  a stalled output backs up into the queue, then stalls the input
// ----------------------------------------------------------------------------
module markup_token_lexer_unit import mtl_pkg::*; #(
	parameter int QDepth = QueueDepth
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_item_t  byte_item,
	output logic      tok_valid,
	input  logic      tok_stall,
	output out_item_t tok_item
);

	logic    accept;
	logic    push;
	logic    full;
	logic    pop;
	logic    head_valid;
	bundle_t bundle;
	bundle_t head;

	assign byte_stall = full;
	assign accept     = byte_valid && !full;

	mtl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (byte_item),
		.push   (push),
		.bundle (bundle)
	);

	mtl_queue #(
		.QDepth (QDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_data    (bundle),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	mtl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (tok_valid),
		.out_stall  (tok_stall),
		.out_data   (tok_item)
	);

endmodule
